[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define OCU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");

// Clocked check that also holds during reset.
`define OCU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

[rtl/ocu_pkg.sv]
// Shared constants, types and tables of the orbit camera update block.
package ocu_pkg;

  localparam int ANGLE_FRAC_BITS   = 12;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int CNT_W             = 5;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint K_Q30       = 64'sd652032874;
  localparam longint TWO_PI_Q    = (((2 * PI_Q30) >>> (29 - ANGLE_FRAC_BITS)) + 1) >>> 1;
  localparam longint HALF_PI_Q   = PI_Q30 >>> (31 - ANGLE_FRAC_BITS);
  localparam longint QUARTER_PI_Q = TWO_PI_Q / 8;
  localparam longint EIGHTH_PI_Q = QUARTER_PI_Q / 2;
  localparam longint SNAP_Q      = (((PI_Q30 / 60) >>> (29 - ANGLE_FRAC_BITS)) + 1) >>> 1;
  localparam int     Z_SHIFT     = 30 - ANGLE_FRAC_BITS;

  localparam int YAW_W  = 15;
  localparam int ANG_W  = 14;
  localparam int ZOOM_W = 24;
  localparam int DZ_W   = 17;
  localparam int POS_W  = 25;
  localparam int UP_W   = 16;
  localparam int Z_W    = 35;
  localparam int XY_W   = 33;
  localparam int SC_W   = 32;

  localparam logic [1:0] REG_ORTHO    = 2'd0;
  localparam logic [1:0] REG_SNAP     = 2'd1;
  localparam logic [1:0] REG_ZOOM_MIN = 2'd2;
  localparam logic [1:0] REG_ZOOM_MAX = 2'd3;

  localparam logic [2:0] MOP_CC  = 3'd0;
  localparam logic [2:0] MOP_SC  = 3'd1;
  localparam logic [2:0] MOP_UPX = 3'd2;
  localparam logic [2:0] MOP_UPZ = 3'd3;
  localparam logic [2:0] MOP_PX  = 3'd4;
  localparam logic [2:0] MOP_PY  = 3'd5;
  localparam logic [2:0] MOP_PZ  = 3'd6;
  localparam logic [2:0] MOP_END = 3'd7;

  typedef struct packed {
    logic             update;
    logic             snap_sub;
    logic             snap_fix;
    logic             cor_load;
    logic             cor_fold;
    logic             cor_step;
    logic             cor_store;
    logic             pass_yaw;
    logic [CNT_W-1:0] iter;
    logic             mul_en;
    logic [2:0]       mul_op;
    logic             wb_en;
    logic [2:0]       wb_op;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic snap_done;
  } status_t;

  // arctan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

[rtl/ocu_ctrl.sv]
// Sequencer: steps the datapath through update, snap, two CORDIC passes and products.
module ocu_ctrl #(
  parameter int CORDIC_ITERATIONS = ocu_pkg::CORDIC_ITERATIONS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ocu_pkg::status_t status,
  output ocu_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SNAP  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  localparam logic [ocu_pkg::CNT_W-1:0] ITER_LAST =
    ocu_pkg::CNT_W'(CORDIC_ITERATIONS - 1);

  logic [2:0]                state, state_next;
  logic                      pass, pass_next;
  logic [ocu_pkg::CNT_W-1:0] iter, iter_next;
  logic [2:0]                mstep, mstep_next;
  logic                      out_valid_next;

  always_comb begin
    state_next     = state;
    pass_next      = pass;
    iter_next      = iter;
    mstep_next     = mstep;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.pass_yaw   = pass;
    cmd.iter       = iter;
    cmd.mul_op     = mstep;
    cmd.wb_op      = mstep - 3'd1;
    in_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.update = 1'b1;
          state_next = S_SNAP;
        end
      end
      S_SNAP: begin
        if (status.snap_done) begin
          cmd.snap_fix = 1'b1;
          pass_next    = 1'b0;
          state_next   = S_LOAD;
        end else begin
          cmd.snap_sub = 1'b1;
        end
      end
      S_LOAD: begin
        cmd.cor_load = 1'b1;
        state_next   = S_FOLD;
      end
      S_FOLD: begin
        cmd.cor_fold = 1'b1;
        iter_next    = '0;
        state_next   = S_ITER;
      end
      S_ITER: begin
        cmd.cor_step = 1'b1;
        if (iter == ITER_LAST) begin
          state_next = S_STORE;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_STORE: begin
        cmd.cor_store = 1'b1;
        if (pass) begin
          mstep_next = '0;
          state_next = S_MUL;
        end else begin
          pass_next  = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_MUL: begin
        // issue product k while writing back product k-1
        cmd.mul_en = (mstep != ocu_pkg::MOP_END);
        cmd.wb_en  = (mstep != ocu_pkg::MOP_CC);
        if (mstep == ocu_pkg::MOP_END) begin
          state_next = S_FIN;
        end else begin
          mstep_next = mstep + 3'd1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= 1'b0;
      iter      <= '0;
      mstep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      iter      <= iter_next;
      mstep     <= mstep_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/ocu_dp.sv]
// Datapath: camera state, config registers, snap reduction, CORDIC and shared multiplier.
module ocu_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [23:0]                         cfg_data,
  input  logic signed [ocu_pkg::ANG_W-1:0]    delta_yaw,
  input  logic signed [ocu_pkg::ANG_W-1:0]    delta_pitch,
  input  logic signed [ocu_pkg::DZ_W-1:0]     delta_zoom,
  input  ocu_pkg::cmd_t                       cmd,
  output ocu_pkg::status_t                    status,
  output logic signed [ocu_pkg::POS_W-1:0]    pos_x,
  output logic signed [ocu_pkg::POS_W-1:0]    pos_y,
  output logic signed [ocu_pkg::POS_W-1:0]    pos_z,
  output logic signed [ocu_pkg::UP_W-1:0]     up_x,
  output logic signed [ocu_pkg::UP_W-1:0]     up_y,
  output logic signed [ocu_pkg::UP_W-1:0]     up_z,
  output logic [ocu_pkg::ZOOM_W-1:0]          view_width,
  output logic [ocu_pkg::YAW_W-1:0]           yaw_now,
  output logic signed [ocu_pkg::ANG_W-1:0]    pitch_now,
  output logic [ocu_pkg::ZOOM_W-1:0]          distance_now
);

  localparam int Z_W  = ocu_pkg::Z_W;
  localparam int XY_W = ocu_pkg::XY_W;
  localparam int SC_W = ocu_pkg::SC_W;

  localparam logic signed [16:0] TWO_PI_A  = 17'(ocu_pkg::TWO_PI_Q);
  localparam logic signed [14:0] HALF_PI_A = 15'(ocu_pkg::HALF_PI_Q);
  localparam logic [15:0]        QUARTER_A = 16'(ocu_pkg::QUARTER_PI_Q);
  localparam logic [15:0]        EIGHTH_A  = 16'(ocu_pkg::EIGHTH_PI_Q);
  localparam logic [15:0]        SNAP_LO   = 16'(ocu_pkg::EIGHTH_PI_Q - ocu_pkg::SNAP_Q);
  localparam logic [15:0]        SNAP_HI   = 16'(ocu_pkg::EIGHTH_PI_Q + ocu_pkg::SNAP_Q);
  localparam logic signed [13:0] SNAP_A    = 14'(ocu_pkg::SNAP_Q);
  localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(ocu_pkg::PI_Q30);
  localparam logic signed [Z_W-1:0] TWO_PI_Z  = Z_W'(2 * ocu_pkg::PI_Q30);
  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(ocu_pkg::PI_Q30 / 2);
  localparam logic signed [XY_W-1:0] K_XY     = XY_W'(ocu_pkg::K_Q30);

  // configuration
  logic        ortho_mode, snap_enable;
  logic [23:0] zoom_min, zoom_max;

  // camera state
  logic [ocu_pkg::YAW_W-1:0]        yaw_angle;
  logic signed [ocu_pkg::ANG_W-1:0] pitch_angle;
  logic [ocu_pkg::ZOOM_W-1:0]       orbit_distance, field_of_view;

  // working registers
  logic [15:0]              snap_r;
  logic signed [16:0]       ang_yaw;
  logic signed [13:0]       ang_pitch;
  logic signed [Z_W-1:0]    z;
  logic signed [XY_W-1:0]   x, y;
  logic                     neg;
  logic signed [SC_W-1:0]   sy, cy, sp, cp, pcc, psc;
  logic signed [63:0]       prod;
  logic signed [ocu_pkg::POS_W-1:0] px_r, py_r, pz_r;
  logic signed [ocu_pkg::UP_W-1:0]  ux_r, uz_r;

  // update logic
  logic signed [16:0] yaw_sum, yaw_wrap;
  logic [ocu_pkg::YAW_W-1:0] yaw_upd;
  logic signed [14:0] pitch_sum, pitch_sat;
  logic [ocu_pkg::ZOOM_W-1:0] zoom_src, zoom_upd;
  logic signed [25:0] zoom_sum, zoom_lo, zmin_s, zmax_s;

  always_comb begin
    yaw_sum = $signed({2'b00, yaw_angle}) + 17'(delta_yaw);
    if (yaw_sum < 0) begin
      yaw_wrap = yaw_sum + TWO_PI_A;
    end else if (yaw_sum >= TWO_PI_A) begin
      yaw_wrap = yaw_sum - TWO_PI_A;
    end else begin
      yaw_wrap = yaw_sum;
    end
    yaw_upd = yaw_wrap[ocu_pkg::YAW_W-1:0];

    pitch_sum = 15'(pitch_angle) + 15'(delta_pitch);
    if (pitch_sum < -HALF_PI_A) begin
      pitch_sat = -HALF_PI_A;
    end else if (pitch_sum > HALF_PI_A) begin
      pitch_sat = HALF_PI_A;
    end else begin
      pitch_sat = pitch_sum;
    end

    zoom_src = ortho_mode ? field_of_view : orbit_distance;
    zoom_sum = $signed({2'b00, zoom_src}) + 26'(delta_zoom);
    zmin_s   = $signed({2'b00, zoom_min});
    zmax_s   = $signed({2'b00, zoom_max});
    // upper bound applied last
    zoom_lo  = (zoom_sum < zmin_s) ? zmin_s : zoom_sum;
    zoom_upd = (zoom_lo > zmax_s) ? zoom_max : zoom_lo[ocu_pkg::ZOOM_W-1:0];
  end

  assign status.snap_done = (snap_r < QUARTER_A);

  always_ff @(posedge clk) begin
    if (rst) begin
      ortho_mode     <= 1'b0;
      snap_enable    <= 1'b0;
      zoom_min       <= 24'd256;
      zoom_max       <= 24'd25600;
      yaw_angle      <= '0;
      pitch_angle    <= '0;
      orbit_distance <= 24'd2560;
      field_of_view  <= 24'd11520;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ocu_pkg::REG_ORTHO:    ortho_mode  <= cfg_data[0];
          ocu_pkg::REG_SNAP:     snap_enable <= cfg_data[0];
          ocu_pkg::REG_ZOOM_MIN: zoom_min    <= cfg_data;
          ocu_pkg::REG_ZOOM_MAX: zoom_max    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.update) begin
        yaw_angle   <= yaw_upd;
        pitch_angle <= pitch_sat[ocu_pkg::ANG_W-1:0];
        if (ortho_mode) begin
          field_of_view <= zoom_upd;
        end else begin
          orbit_distance <= zoom_upd;
        end
      end
    end
  end

  // snap: reduce yaw + pi/8 modulo pi/4 one subtraction a cycle
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      snap_r <= {1'b0, yaw_upd} + EIGHTH_A;
    end else if (cmd.snap_sub) begin
      snap_r <= snap_r - QUARTER_A;
    end
    if (cmd.snap_fix) begin
      if (snap_enable && snap_r > SNAP_LO && snap_r < SNAP_HI) begin
        ang_yaw <= $signed({2'b00, yaw_angle}) - $signed({1'b0, snap_r}) + $signed({1'b0, EIGHTH_A});
      end else begin
        ang_yaw <= $signed({2'b00, yaw_angle});
      end
      if (snap_enable && pitch_angle > -SNAP_A && pitch_angle < SNAP_A) begin
        ang_pitch <= '0;
      end else begin
        ang_pitch <= pitch_angle;
      end
    end
  end

  // CORDIC, rotation mode
  logic signed [16:0]     ang_sel;
  logic signed [Z_W-1:0]  z_in;
  logic signed [XY_W-1:0] xs, ys, xf, yf;
  logic signed [Z_W-1:0]  at;

  always_comb begin
    ang_sel = cmd.pass_yaw ? ang_yaw : 17'(ang_pitch);
    z_in    = Z_W'(ang_sel) <<< ocu_pkg::Z_SHIFT;
    xs      = x >>> cmd.iter;
    ys      = y >>> cmd.iter;
    at      = $signed({{(Z_W-30){1'b0}}, ocu_pkg::atan_q30(cmd.iter)});
    xf      = neg ? -x : x;
    yf      = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (cmd.cor_load) begin
      if (z_in > PI_Z) begin
        z <= z_in - TWO_PI_Z;
      end else if (z_in <= -PI_Z) begin
        z <= z_in + TWO_PI_Z;
      end else begin
        z <= z_in;
      end
    end else if (cmd.cor_fold) begin
      x <= K_XY;
      y <= '0;
      if (z > HALF_PI_Z) begin
        z   <= z - PI_Z;
        neg <= 1'b1;
      end else if (z < -HALF_PI_Z) begin
        z   <= z + PI_Z;
        neg <= 1'b1;
      end else begin
        neg <= 1'b0;
      end
    end else if (cmd.cor_step) begin
      if (!z[Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (cmd.cor_store) begin
      if (cmd.pass_yaw) begin
        cy <= xf[SC_W-1:0];
        sy <= yf[SC_W-1:0];
      end else begin
        cp <= xf[SC_W-1:0];
        sp <= yf[SC_W-1:0];
      end
    end
  end

  // shared multiplier and write-back
  function automatic logic signed [ocu_pkg::UP_W-1:0] sat_up(input logic signed [17:0] v);
    logic signed [ocu_pkg::UP_W-1:0] r;
    if (v > 18'sd16384) begin
      r = 16'sd16384;
    end else if (v < -18'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[ocu_pkg::UP_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [16:0] rnd16(input logic signed [SC_W-1:0] v);
    logic signed [SC_W:0] t;
    t = (SC_W+1)'(v) + 33'sd32768;
    return t[SC_W:16];
  endfunction

  function automatic logic signed [ocu_pkg::POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [ocu_pkg::POS_W-1:0] r;
    if (v > 64'sd16777215) begin
      r = 25'sd16777215;
    end else if (v < -64'sd16777215) begin
      r = -25'sd16777215;
    end else begin
      r = v[ocu_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  logic signed [SC_W-1:0] opa, opb, dext;
  logic signed [63:0]     r30;

  always_comb begin
    dext = $signed({{(SC_W-ocu_pkg::ZOOM_W){1'b0}}, orbit_distance});
    unique case (cmd.mul_op)
      ocu_pkg::MOP_CC:  begin opa = cy;   opb = cp;  end
      ocu_pkg::MOP_SC:  begin opa = sy;   opb = cp;  end
      ocu_pkg::MOP_UPX: begin opa = cy;   opb = sp;  end
      ocu_pkg::MOP_UPZ: begin opa = sy;   opb = sp;  end
      ocu_pkg::MOP_PX:  begin opa = dext; opb = pcc; end
      ocu_pkg::MOP_PY:  begin opa = dext; opb = sp;  end
      ocu_pkg::MOP_PZ:  begin opa = dext; opb = psc; end
      default:          begin opa = '0;   opb = '0;  end
    endcase
    r30 = (prod + 64'sd536870912) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= 64'(opa) * 64'(opb);
    end
    if (cmd.wb_en) begin
      unique case (cmd.wb_op)
        ocu_pkg::MOP_CC:  pcc  <= r30[SC_W-1:0];
        ocu_pkg::MOP_SC:  psc  <= r30[SC_W-1:0];
        ocu_pkg::MOP_UPX: ux_r <= sat_up(-18'(rnd16(r30[SC_W-1:0])));
        ocu_pkg::MOP_UPZ: uz_r <= sat_up(-18'(rnd16(r30[SC_W-1:0])));
        ocu_pkg::MOP_PX:  px_r <= sat_pos(r30);
        ocu_pkg::MOP_PY:  py_r <= sat_pos(r30);
        ocu_pkg::MOP_PZ:  pz_r <= sat_pos(r30);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x        <= px_r;
      pos_y        <= py_r;
      pos_z        <= pz_r;
      up_x         <= ux_r;
      up_y         <= sat_up(18'(rnd16(cp)));
      up_z         <= uz_r;
      view_width   <= field_of_view;
      yaw_now      <= yaw_angle;
      pitch_now    <= pitch_angle;
      distance_now <= orbit_distance;
    end
  end

endmodule

[rtl/orbit_camera_update.sv]
// Orbit camera update: angle and zoom accumulation, sin/cos by CORDIC, position and up vector.
// Each request updates the stored yaw, pitch and zoom, then runs one shared CORDIC twice
// (pitch, then yaw) and one shared 32x32 multiplier for seven products. One request is in
// flight at a time; the next is taken as soon as the result sits in the output register,
// even if not yet taken.
module orbit_camera_update #(
  parameter int CORDIC_ITERATIONS = ocu_pkg::CORDIC_ITERATIONS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [23:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ocu_pkg::ANG_W-1:0]  delta_yaw,
  input  logic signed [ocu_pkg::ANG_W-1:0]  delta_pitch,
  input  logic signed [ocu_pkg::DZ_W-1:0]   delta_zoom,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ocu_pkg::POS_W-1:0]  pos_x,
  output logic signed [ocu_pkg::POS_W-1:0]  pos_y,
  output logic signed [ocu_pkg::POS_W-1:0]  pos_z,
  output logic signed [ocu_pkg::UP_W-1:0]   up_x,
  output logic signed [ocu_pkg::UP_W-1:0]   up_y,
  output logic signed [ocu_pkg::UP_W-1:0]   up_z,
  output logic [ocu_pkg::ZOOM_W-1:0]        view_width,
  output logic [ocu_pkg::YAW_W-1:0]         yaw_now,
  output logic signed [ocu_pkg::ANG_W-1:0]  pitch_now,
  output logic [ocu_pkg::ZOOM_W-1:0]        distance_now
);

  ocu_pkg::cmd_t    cmd;
  ocu_pkg::status_t status;

  ocu_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ocu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .delta_yaw   (delta_yaw),
    .delta_pitch (delta_pitch),
    .delta_zoom  (delta_zoom),
    .cmd         (cmd),
    .status      (status),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .up_x        (up_x),
    .up_y        (up_y),
    .up_z        (up_z),
    .view_width  (view_width),
    .yaw_now     (yaw_now),
    .pitch_now   (pitch_now),
    .distance_now(distance_now)
  );

endmodule

[rtl/ocu_checker.sv]
// Port-level checks of the orbit camera update block, bound to the top level.
`include "assert_macros.svh"

module ocu_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ocu_pkg::UP_W-1:0]   up_y,
  input logic [ocu_pkg::YAW_W-1:0]         yaw_now,
  input logic signed [ocu_pkg::ANG_W-1:0]  pitch_now
);

  `OCU_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `OCU_ASSERT(a_busy_after_req, clk, rst, in_valid && in_ready |=> !in_ready)
  `OCU_ASSERT(a_yaw_range, clk, rst, out_valid |-> yaw_now < 15'd25736)
  `OCU_ASSERT(a_pitch_range, clk, rst, out_valid |-> pitch_now <= 14'sd6433 && pitch_now >= -14'sd6433)
  `OCU_ASSERT(a_upy_range, clk, rst, out_valid |-> up_y <= 16'sd16384 && up_y >= -16'sd16384)

endmodule

bind orbit_camera_update ocu_props u_ocu_props (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .up_y     (up_y),
  .yaw_now  (yaw_now),
  .pitch_now(pitch_now)
);

[verif/ocu_checker.sv]
// Checker for the orbit camera update block: expected-result prediction and comparison.
`timescale 1ns / 1ps
module ocu_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [23:0]                       cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [ocu_pkg::ANG_W-1:0]  delta_yaw,
  input  logic signed [ocu_pkg::ANG_W-1:0]  delta_pitch,
  input  logic signed [ocu_pkg::DZ_W-1:0]   delta_zoom,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [ocu_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ocu_pkg::POS_W-1:0]  pos_y,
  input  logic signed [ocu_pkg::POS_W-1:0]  pos_z,
  input  logic signed [ocu_pkg::UP_W-1:0]   up_x,
  input  logic signed [ocu_pkg::UP_W-1:0]   up_y,
  input  logic signed [ocu_pkg::UP_W-1:0]   up_z,
  input  logic [ocu_pkg::ZOOM_W-1:0]        view_width,
  input  logic [ocu_pkg::YAW_W-1:0]         yaw_now,
  input  logic signed [ocu_pkg::ANG_W-1:0]  pitch_now,
  input  logic [ocu_pkg::ZOOM_W-1:0]        distance_now,
  output int                                errors,
  output int                                pending
);

  typedef struct {
    logic signed [ocu_pkg::POS_W-1:0] px, py, pz;
    logic signed [ocu_pkg::UP_W-1:0]  ux, uy, uz;
    logic [ocu_pkg::ZOOM_W-1:0]       vw;
    logic [ocu_pkg::YAW_W-1:0]        yaw;
    logic signed [ocu_pkg::ANG_W-1:0] pitch;
    logic [ocu_pkg::ZOOM_W-1:0]       dnow;
  } pose_t;

  localparam longint ARCTAN [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  logic   ortho, snap;
  longint zmin, zmax, yaw_acc, pitch_acc, dist_acc, fov_acc;
  pose_t  pose_q[$];

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Rotation-mode CORDIC, angle in Q12, sin/cos in Q30.
  function automatic void cordic_sincos(input longint a, output longint s, output longint c);
    longint z, x, y, nx;
    bit     flip;
    int     n;
    z = a <<< ocu_pkg::Z_SHIFT;
    x = ocu_pkg::K_Q30;
    y = 0;
    flip = 0;
    n = (ocu_pkg::CORDIC_ITERATIONS > 24) ? 24 : ocu_pkg::CORDIC_ITERATIONS;
    while (z > ocu_pkg::PI_Q30) z -= 2 * ocu_pkg::PI_Q30;
    while (z <= -ocu_pkg::PI_Q30) z += 2 * ocu_pkg::PI_Q30;
    if (z > ocu_pkg::PI_Q30 / 2) begin
      z -= ocu_pkg::PI_Q30;
      flip = 1;
    end else if (z < -(ocu_pkg::PI_Q30 / 2)) begin
      z += ocu_pkg::PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t camera_pose(input longint dy, input longint dp, input longint dz);
    pose_t  p;
    longint t, yw, pt, e, sy, cy, sp, cp;
    t = (yaw_acc + dy) % ocu_pkg::TWO_PI_Q;
    if (t < 0) t += ocu_pkg::TWO_PI_Q;
    yaw_acc = t;
    pitch_acc = clip(pitch_acc + dp, -ocu_pkg::HALF_PI_Q, ocu_pkg::HALF_PI_Q);
    // upper bound applied last, so inverted bounds give zoom_max
    if (ortho) fov_acc = clip(fov_acc + dz, zmin, zmax);
    else dist_acc = clip(dist_acc + dz, zmin, zmax);
    yw = yaw_acc;
    pt = pitch_acc;
    if (snap) begin
      e = (yaw_acc + ocu_pkg::EIGHTH_PI_Q) % ocu_pkg::QUARTER_PI_Q - ocu_pkg::EIGHTH_PI_Q;
      if (e > -ocu_pkg::SNAP_Q && e < ocu_pkg::SNAP_Q) yw -= e;
      if (pitch_acc > -ocu_pkg::SNAP_Q && pitch_acc < ocu_pkg::SNAP_Q) pt = 0;
    end
    cordic_sincos(yw, sy, cy);
    cordic_sincos(pt, sp, cp);
    p.px = ocu_pkg::POS_W'(clip(round_shift(dist_acc * round_shift(cy * cp, 30), 30),
                                -16777215, 16777215));
    p.py = ocu_pkg::POS_W'(clip(round_shift(dist_acc * sp, 30), -16777215, 16777215));
    p.pz = ocu_pkg::POS_W'(clip(round_shift(dist_acc * round_shift(sy * cp, 30), 30),
                                -16777215, 16777215));
    p.ux = ocu_pkg::UP_W'(clip(-round_shift(round_shift(cy * sp, 30), 16), -16384, 16384));
    p.uy = ocu_pkg::UP_W'(clip(round_shift(cp, 16), -16384, 16384));
    p.uz = ocu_pkg::UP_W'(clip(-round_shift(round_shift(sy * sp, 30), 16), -16384, 16384));
    p.vw = ocu_pkg::ZOOM_W'(fov_acc);
    p.yaw = ocu_pkg::YAW_W'(yaw_acc);
    p.pitch = ocu_pkg::ANG_W'(pitch_acc);
    p.dnow = ocu_pkg::ZOOM_W'(dist_acc);
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t w;
    if (rst) begin
      ortho <= 0;
      snap <= 0;
      zmin = 256;
      zmax = 25600;
      yaw_acc = 0;
      pitch_acc = 0;
      dist_acc = 2560;
      fov_acc = 11520;
      errors <= 0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ocu_pkg::REG_ORTHO:    ortho <= cfg_data[0];
          ocu_pkg::REG_SNAP:     snap <= cfg_data[0];
          ocu_pkg::REG_ZOOM_MIN: zmin = longint'(cfg_data);
          ocu_pkg::REG_ZOOM_MAX: zmax = longint'(cfg_data);
        endcase
      end
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          w = pose_q.pop_front();
          if (pos_x !== w.px || pos_y !== w.py || pos_z !== w.pz || up_x !== w.ux ||
              up_y !== w.uy || up_z !== w.uz || view_width !== w.vw || yaw_now !== w.yaw ||
              pitch_now !== w.pitch || distance_now !== w.dnow)
            errors <= errors + 1;
          if (pos_x !== w.px) $error("pos_x expected %0d got %0d", w.px, pos_x);
          if (pos_y !== w.py) $error("pos_y expected %0d got %0d", w.py, pos_y);
          if (pos_z !== w.pz) $error("pos_z expected %0d got %0d", w.pz, pos_z);
          if (up_x !== w.ux) $error("up_x expected %0d got %0d", w.ux, up_x);
          if (up_y !== w.uy) $error("up_y expected %0d got %0d", w.uy, up_y);
          if (up_z !== w.uz) $error("up_z expected %0d got %0d", w.uz, up_z);
          if (view_width !== w.vw) $error("view_width expected %0d got %0d", w.vw, view_width);
          if (yaw_now !== w.yaw) $error("yaw_now expected %0d got %0d", w.yaw, yaw_now);
          if (pitch_now !== w.pitch)
            $error("pitch_now expected %0d got %0d", w.pitch, pitch_now);
          if (distance_now !== w.dnow)
            $error("distance_now expected %0d got %0d", w.dnow, distance_now);
        end
      end
      if (in_valid && in_ready)
        pose_q.push_back(camera_pose(longint'(delta_yaw), longint'(delta_pitch),
                                     longint'(delta_zoom)));
    end
    pending <= pose_q.size();
  end
endmodule

[verif/tb_orbit_camera_update.sv]
// Testbench top for the orbit camera update block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_orbit_camera_update;

  localparam int STALL_LIMIT = 3000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = ocu_pkg::REG_ORTHO;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [ocu_pkg::ANG_W-1:0] delta_yaw = '0, delta_pitch = '0;
  logic signed [ocu_pkg::DZ_W-1:0] delta_zoom = '0;
  logic signed [ocu_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [ocu_pkg::UP_W-1:0] up_x, up_y, up_z;
  logic [ocu_pkg::ZOOM_W-1:0] view_width, distance_now;
  logic [ocu_pkg::YAW_W-1:0] yaw_now;
  logic signed [ocu_pkg::ANG_W-1:0] pitch_now;
  int errors, pending, sent, idle_cycles;
  bit calm;

  always #6 clk = ~clk;

  orbit_camera_update dut (.*);

  ocu_checker chk (.*);

  // Receiver stalls, except in the calm stretch.
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 14);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_orbit_camera_update: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Drop the request, wait for every outstanding result, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic request(input int dy, input int dp, input int dz);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    delta_yaw <= ocu_pkg::ANG_W'(dy);
    delta_pitch <= ocu_pkg::ANG_W'(dp);
    delta_zoom <= ocu_pkg::DZ_W'(dz);
    // in_ready is stable at the falling edge, so acceptance is known here
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    sent++;
    calm = (sent >= 300 && sent < 420);
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 60)
        request($urandom_range(800) - 400, $urandom_range(600) - 300,
                $urandom_range(8000) - 4000);
      else
        request($urandom_range(16383) - 8192, $urandom_range(16383) - 8192,
                $urandom_range(131071) - 65536);
    end
  endtask

  task automatic directed();
    request(0, 0, 0);
    request(-8192, -8192, -65536);
    request(8191, 8191, 65535);
    request(8191, 8191, 65535);
    request(-8192, -8192, -65536);
    request(3217 + 100, 0, 0);
    request(-3217, 213, 0);
    request(3217 + 214, -426, 0);
    request(-428, 214, 1);
    request(5, -1, -1);
    request(25735, 0, 0);
    request(1, 6433, 0);
  endtask

  initial begin
    sent = 0;
    calm = 0;
    repeat (5) @(negedge clk);
    rst <= 0;
    directed();
    random_burst(150);
    drain();
    // snapping on, widest zoom range
    write_reg(ocu_pkg::REG_SNAP, 24'd1);
    write_reg(ocu_pkg::REG_ZOOM_MIN, 24'd0);
    write_reg(ocu_pkg::REG_ZOOM_MAX, 24'hFFFFFF);
    directed();
    random_burst(250);
    drain();
    // orthographic, inverted bounds
    write_reg(ocu_pkg::REG_ORTHO, 24'd1);
    write_reg(ocu_pkg::REG_SNAP, 24'd0);
    write_reg(ocu_pkg::REG_ZOOM_MIN, 24'hFFFFFF);
    write_reg(ocu_pkg::REG_ZOOM_MAX, 24'd1000);
    random_burst(120);
    drain();
    write_reg(ocu_pkg::REG_ZOOM_MIN, 24'd0);
    write_reg(ocu_pkg::REG_ZOOM_MAX, 24'hFFFFFF);
    write_reg(ocu_pkg::REG_SNAP, 24'd1);
    directed();
    random_burst(250);
    drain();
    // back to orbit distance, full range then narrow bounds
    write_reg(ocu_pkg::REG_ORTHO, 24'd0);
    for (int i = 0; i < 300; i++) request(0, 0, 65535);
    random_burst(150);
    drain();
    write_reg(ocu_pkg::REG_ZOOM_MIN, 24'd5000);
    write_reg(ocu_pkg::REG_ZOOM_MAX, 24'd5000);
    write_reg(ocu_pkg::REG_SNAP, 24'd0);
    random_burst(150);
    drain();
    if (errors == 0) $display("tb_orbit_camera_update: PASS");
    else $display("tb_orbit_camera_update: FAIL");
    $finish;
  end
endmodule
